// ===== hdl/rem_pkg.sv =====
// Package with the shared types, constants and codes of the RED ECN marker.
`timescale 1ns / 1ps
`default_nettype none
package rem_pkg;

    localparam int QUEUE_DEPTH_DEF   = 1024;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int FACT_BITS         = 24;
    localparam int IDLE_W            = 10;
    localparam int DIV_STEPS         = 17;
    localparam int CFG_INDEX_W       = 3;
    localparam int CFG_DATA_W        = 16;

    localparam logic [1:0]  ECN_NOT_ECT = 2'd0;
    localparam logic [1:0]  ECN_CE      = 2'd3;
    localparam logic [16:0] COUNT_MAX   = 17'sd65535;

    typedef enum logic [2:0] {
        CFG_MIN_THRESHOLD   = 3'd0,
        CFG_MAX_THRESHOLD   = 3'd1,
        CFG_MAX_PROBABILITY = 3'd2,
        CFG_WEIGHT_SHIFT    = 3'd3,
        CFG_CAPACITY        = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        VERDICT_FORWARD = 2'd0,
        VERDICT_MARK    = 2'd1,
        VERDICT_DROP    = 2'd2
    } verdict_t;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_ZERO = 2'd1,
        CNT_NEG  = 2'd2,
        CNT_INC  = 2'd3
    } cnt_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EWMA,
        ST_DEC_INIT,
        ST_DEC_R,
        ST_DEC_B,
        ST_DEC_FIN,
        ST_DECIDE,
        ST_PB_MUL,
        ST_PB_DIV,
        ST_PB_LATCH,
        ST_CPB_MUL,
        ST_PA_CHECK,
        ST_PA_DIV,
        ST_PA_DONE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic     load;
        logic     ewma;
        logic     dec_init;
        logic     dec_mul_r;
        logic     dec_mul_b;
        logic     dec_final;
        logic     mul_pb;
        logic     div_pb_start;
        logic     div_pa_start;
        logic     div_step;
        logic     pb_latch;
        logic     mul_cpb;
        cnt_op_t  cnt_op;
        logic     set_pending;
        logic     clr_pending;
        logic     res_load;
        verdict_t res;
        logic     out_write;
    } cmd_t;

    typedef struct packed {
        logic pass_through;
        logic ecn_zero;
        logic ecn_ce;
        logic q_zero;
        logic idle_bit;
        logic over_limit;
        logic in_band;
        logic above_max;
        logic cpb_sat;
        logic pa_ovf;
        logic mark_hit;
        logic out_busy;
    } status_t;

endpackage
`default_nettype wire

// ===== hdl/red_ecn_marker_unit.sv =====
// Top level of the RED ECN marker: controller and datapath joined.
//
//   channel  direction  handshake           payload
//   s_       in         s_valid / s_ready   ecn_bits, queue_length, idle_slots, random_value
//   m_       out        m_valid / m_ready   verdict
//   cfg_     in         cfg_we              cfg_index, cfg_wdata
//
// A packet with a pending mark goes from the check state straight to the result.
// Otherwise averaging is a single update, or a decay over the idle bits on an empty queue,
// and the band case adds the two 17-step serial divisions and the shared multiplier.
// The unit returns to idle once the result is written to the output register, and
// only then takes the next transfer.
// Reset is synchronous and active low; no clearing pass is needed.
// A new transfer is taken while the previous result still waits on m_ready.
`timescale 1ns / 1ps
`default_nettype none
module red_ecn_marker_unit
    import rem_pkg::*;
#(
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [1:0]             s_ecn_bits,
    input  wire logic [10:0]            s_queue_length,
    input  wire logic [9:0]             s_idle_slots,
    input  wire logic [15:0]            s_random_value,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [1:0]                  m_verdict
);

    cmd_t    cmd;
    status_t stat;

    rem_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rem_dpath #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_ecn_bits     (s_ecn_bits),
        .s_queue_length (s_queue_length),
        .s_idle_slots   (s_idle_slots),
        .s_random_value (s_random_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_verdict      (m_verdict),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule
`default_nettype wire

// ===== hdl/rem_ctrl.sv =====
// Controller state machine that sequences the marker datapath for one packet.
`timescale 1ns / 1ps
`default_nettype none
module rem_ctrl
    import rem_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire status_t stat,
    output cmd_t         cmd
);

    localparam logic [4:0] DEC_LAST = 5'(IDLE_W - 1);
    localparam logic [4:0] DIV_LAST = 5'(DIV_STEPS - 1);

    state_t     state_reg, state_next;
    logic [4:0] iter_reg, iter_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            iter_reg  <= 5'd0;
        end else begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        iter_next  = iter_reg;
        cmd        = '0;
        cmd.cnt_op = CNT_HOLD;
        cmd.res    = VERDICT_FORWARD;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (stat.pass_through) begin
                    cmd.clr_pending = 1'b1;
                    cmd.res_load    = 1'b1;
                    cmd.res         = VERDICT_MARK;
                    state_next      = ST_OUT;
                end else if (stat.q_zero) begin
                    state_next = ST_DEC_INIT;
                end else begin
                    state_next = ST_EWMA;
                end
            end
            ST_EWMA: begin
                cmd.ewma   = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DEC_INIT: begin
                cmd.dec_init = 1'b1;
                iter_next    = 5'd0;
                state_next   = ST_DEC_R;
            end
            ST_DEC_R: begin
                cmd.dec_mul_r = stat.idle_bit;
                state_next    = ST_DEC_B;
            end
            ST_DEC_B: begin
                cmd.dec_mul_b = 1'b1;
                iter_next     = iter_reg + 5'd1;
                state_next    = (iter_reg == DEC_LAST) ? ST_DEC_FIN : ST_DEC_R;
            end
            ST_DEC_FIN: begin
                cmd.dec_final = 1'b1;
                state_next    = ST_DECIDE;
            end
            ST_DECIDE: begin
                state_next   = ST_OUT;
                cmd.res_load = 1'b1;
                if (stat.over_limit) begin
                    cmd.cnt_op = CNT_ZERO;
                    cmd.res    = VERDICT_DROP;
                end else if (stat.ecn_zero) begin
                    cmd.cnt_op = CNT_NEG;
                end else if (stat.in_band) begin
                    cmd.cnt_op   = CNT_INC;
                    cmd.res_load = 1'b0;
                    state_next   = ST_PB_MUL;
                end else if (stat.above_max) begin
                    cmd.cnt_op      = CNT_ZERO;
                    cmd.set_pending = stat.ecn_ce;
                    cmd.res         = stat.ecn_ce ? VERDICT_FORWARD : VERDICT_MARK;
                end else begin
                    cmd.cnt_op = CNT_NEG;
                end
            end
            ST_PB_MUL: begin
                cmd.mul_pb = 1'b1;
                state_next = ST_PB_DIV;
                iter_next  = 5'd0;
            end
            ST_PB_DIV: begin
                cmd.div_pb_start = (iter_reg == 5'd0);
                cmd.div_step     = (iter_reg != 5'd0);
                iter_next        = iter_reg + 5'd1;
                if (iter_reg == DIV_LAST + 5'd1) begin
                    state_next = ST_PB_LATCH;
                end
            end
            ST_PB_LATCH: begin
                cmd.pb_latch = 1'b1;
                state_next   = ST_CPB_MUL;
            end
            ST_CPB_MUL: begin
                cmd.mul_cpb = 1'b1;
                state_next  = ST_PA_CHECK;
            end
            ST_PA_CHECK: begin
                if (stat.cpb_sat || stat.pa_ovf) begin
                    cmd.cnt_op      = CNT_ZERO;
                    cmd.res_load    = 1'b1;
                    cmd.set_pending = stat.ecn_ce;
                    cmd.res         = stat.ecn_ce ? VERDICT_FORWARD : VERDICT_MARK;
                    state_next      = ST_OUT;
                end else begin
                    cmd.div_pa_start = 1'b1;
                    iter_next        = 5'd0;
                    state_next       = ST_PA_DIV;
                end
            end
            ST_PA_DIV: begin
                cmd.div_step = 1'b1;
                iter_next    = iter_reg + 5'd1;
                if (iter_reg == DIV_LAST) begin
                    state_next = ST_PA_DONE;
                end
            end
            ST_PA_DONE: begin
                cmd.res_load = 1'b1;
                state_next   = ST_OUT;
                if (stat.mark_hit) begin
                    cmd.cnt_op      = CNT_ZERO;
                    cmd.set_pending = stat.ecn_ce;
                    cmd.res         = stat.ecn_ce ? VERDICT_FORWARD : VERDICT_MARK;
                end
            end
            ST_OUT: begin
                if (!stat.out_busy) begin
                    cmd.out_write = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/rem_dpath.sv =====
// Datapath of the marker: registers, averaging, shared multiplier and divider.
`timescale 1ns / 1ps
`default_nettype none
module rem_dpath
    import rem_pkg::*;
#(
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic [1:0]             s_ecn_bits,
    input  wire logic [10:0]            s_queue_length,
    input  wire logic [9:0]             s_idle_slots,
    input  wire logic [15:0]            s_random_value,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [1:0]                  m_verdict,
    input  wire cmd_t                   cmd,
    output status_t                     stat
);

    localparam int AW = 11 + FRACTION_BITS;
    localparam int EW = AW + 16;
    localparam int MA = (AW > 25) ? AW : 25;
    localparam int PW = MA + 25;
    localparam int NW = AW + 16;

    logic [10:0] min_reg, max_reg, cap_reg;
    logic [15:0] maxp_reg;
    logic [3:0]  ws_reg;

    logic [1:0]         ecn_reg;
    logic [10:0]        q_reg;
    logic [IDLE_W-1:0]  idle_reg;
    logic [15:0]        rnd_reg;
    logic [AW-1:0]      avg_reg;
    logic signed [16:0] count_reg;
    logic               pending_reg;
    logic [24:0]        r_reg, base_reg;
    logic [NW-1:0]      num_reg;
    logic [AW-1:0]      den_reg;
    logic [AW:0]        rem_reg;
    logic [16:0]        sh_reg;
    logic [16:0]        pb_reg;
    logic [31:0]        cpb_reg;
    verdict_t           res_reg;
    logic               m_valid_reg;
    verdict_t           m_verdict_reg;

    logic [10:0]   q_clamped, limit;
    logic [AW-1:0] minf, maxf;
    logic [EW-1:0] ewma_sum;
    logic [MA-1:0] op_a;
    logic [24:0]   op_b;
    logic [PW-1:0] prod;
    logic [AW+1:0] trial;
    logic          trial_ge;
    logic [16:0]   pa_den, pa_cap;

    assign q_clamped = (32'(s_queue_length) > 32'(QUEUE_DEPTH)) ? 11'(QUEUE_DEPTH)
                                                               : s_queue_length;
    assign limit = (cap_reg > max_reg) ? cap_reg : max_reg;
    assign minf  = {min_reg, {FRACTION_BITS{1'b0}}};
    assign maxf  = {max_reg, {FRACTION_BITS{1'b0}}};

    assign ewma_sum = (EW'(avg_reg) << ws_reg) - EW'(avg_reg)
                    + (EW'(q_reg) << FRACTION_BITS);

    always_comb begin
        op_a = MA'(r_reg);
        op_b = base_reg;
        if (cmd.dec_mul_b) begin
            op_a = MA'(base_reg);
        end else if (cmd.dec_final) begin
            op_a = MA'(avg_reg);
            op_b = r_reg;
        end else if (cmd.mul_pb) begin
            op_a = MA'(avg_reg - minf);
            op_b = 25'(maxp_reg);
        end else if (cmd.mul_cpb) begin
            op_a = MA'(count_reg[15:0]);
            op_b = 25'(pb_reg);
        end
    end

    assign prod = PW'(op_a) * PW'(op_b);

    assign trial    = {rem_reg, sh_reg[16]};
    assign trial_ge = trial >= (AW+2)'(den_reg);
    assign pa_den   = 17'h10000 - cpb_reg[16:0];
    assign pa_cap   = (sh_reg > 17'h10000) ? 17'h10000 : sh_reg;

    always_comb begin
        stat.pass_through = (ecn_reg != ECN_NOT_ECT) && pending_reg && (ecn_reg != ECN_CE);
        stat.ecn_zero     = (ecn_reg == ECN_NOT_ECT);
        stat.ecn_ce       = (ecn_reg == ECN_CE);
        stat.q_zero       = (q_reg == 11'd0);
        stat.idle_bit     = idle_reg[0];
        stat.over_limit   = (q_reg >= limit);
        stat.in_band      = (minf <= avg_reg) && (avg_reg < maxf);
        stat.above_max    = (avg_reg >= maxf);
        stat.cpb_sat      = |cpb_reg[31:16];
        stat.pa_ovf       = (pb_reg >> 1) >= pa_den;
        stat.mark_hit     = {1'b0, rnd_reg} < pa_cap;
        stat.out_busy     = m_valid_reg && !m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg  <= 11'd5;
            max_reg  <= 11'd15;
            maxp_reg <= 16'd6554;
            ws_reg   <= 4'd9;
            cap_reg  <= 11'd100;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MIN_THRESHOLD:   min_reg  <= cfg_wdata[10:0];
                CFG_MAX_THRESHOLD:   max_reg  <= cfg_wdata[10:0];
                CFG_MAX_PROBABILITY: maxp_reg <= cfg_wdata;
                CFG_WEIGHT_SHIFT:    ws_reg   <= cfg_wdata[3:0];
                CFG_CAPACITY:        cap_reg  <= cfg_wdata[10:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_reg     <= '0;
            count_reg   <= -17'sd1;
            pending_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.ewma) begin
                avg_reg <= AW'(ewma_sum >> ws_reg);
            end else if (cmd.dec_final) begin
                avg_reg <= AW'(prod >> FACT_BITS);
            end
            case (cmd.cnt_op)
                CNT_ZERO: count_reg <= 17'sd0;
                CNT_NEG:  count_reg <= -17'sd1;
                CNT_INC: begin
                    if (count_reg < $signed(COUNT_MAX)) begin
                        count_reg <= count_reg + 17'sd1;
                    end
                end
                default: begin
                end
            endcase
            if (cmd.set_pending) begin
                pending_reg <= 1'b1;
            end else if (cmd.clr_pending) begin
                pending_reg <= 1'b0;
            end
            if (cmd.out_write) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ecn_reg  <= s_ecn_bits;
            q_reg    <= q_clamped;
            idle_reg <= s_idle_slots;
            rnd_reg  <= s_random_value;
        end else if (cmd.dec_mul_b) begin
            idle_reg <= idle_reg >> 1;
        end
        if (cmd.dec_init) begin
            r_reg    <= 25'(1) << FACT_BITS;
            base_reg <= (25'(1) << FACT_BITS) - (25'(1) << (5'(FACT_BITS) - {1'b0, ws_reg}));
        end else if (cmd.dec_mul_r) begin
            r_reg <= 25'(prod >> FACT_BITS);
        end else if (cmd.dec_mul_b) begin
            base_reg <= 25'(prod >> FACT_BITS);
        end
        if (cmd.mul_pb) begin
            num_reg <= NW'(prod);
            den_reg <= maxf - minf;
        end
        if (cmd.div_pb_start) begin
            rem_reg <= (AW+1)'(num_reg >> DIV_STEPS);
            sh_reg  <= num_reg[16:0];
        end else if (cmd.div_pa_start) begin
            rem_reg <= (AW+1)'(pb_reg >> 1);
            sh_reg  <= {pb_reg[0], 16'd0};
            den_reg <= AW'(pa_den);
        end else if (cmd.div_step) begin
            rem_reg <= trial_ge ? (AW+1)'(trial - (AW+2)'(den_reg)) : (AW+1)'(trial);
            sh_reg  <= {sh_reg[15:0], trial_ge};
        end
        if (cmd.pb_latch) begin
            pb_reg <= sh_reg;
        end
        if (cmd.mul_cpb) begin
            cpb_reg <= 32'(prod);
        end
        if (cmd.res_load) begin
            res_reg <= cmd.res;
        end
        if (cmd.out_write) begin
            m_verdict_reg <= res_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_verdict = m_verdict_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_write |-> !(m_valid_reg && !m_ready))
        else $error("Result overwritten before its transfer.");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= -17'sd1) && (count_reg <= $signed(COUNT_MAX)))
        else $error("Mark count left its range.");

    a_one_mult: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.dec_mul_r, cmd.dec_mul_b, cmd.dec_final, cmd.mul_pb, cmd.mul_cpb}))
        else $error("Shared multiplier claimed twice.");

    a_one_div: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.div_pb_start, cmd.div_pa_start, cmd.div_step}))
        else $error("Divider given two commands at once.");

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for the RED ECN marker with a built-in verdict predictor.
`timescale 1ns / 1ps
module tb;
    import rem_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_ecn_bits = '0;
    logic [10:0] s_queue_length = '0;
    logic [9:0]  s_idle_slots = '0;
    logic [15:0] s_random_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_verdict;

    red_ecn_marker_unit uut (.*);

    always #6 aclk = ~aclk;

    typedef struct packed {
        logic [1:0]  ecn;
        logic [10:0] qlen;
        logic [9:0]  idle;
        logic [15:0] rnd;
    } packet_t;

    typedef struct {
        packet_t  pkt;
        logic     known;
        verdict_t want;
    } row_t;

    logic [10:0] min_th, max_th, cap;
    logic [15:0] max_p;
    logic [3:0]  wshift;
    logic [63:0] avg_q;
    int          since_mark;
    logic        pending;

    verdict_t    verdict_queue[$];
    int          mismatches = 0;
    int          errors = 0;
    int          stall_long = 0;
    int          rx_wait = 0;
    int          quiet = 0;
    logic        done = 1'b0;

    task automatic apply_reset_model();
        min_th = 11'd5; max_th = 11'd15; max_p = 16'd6554; wshift = 4'd9; cap = 11'd100;
        avg_q = 64'd0; since_mark = -1; pending = 1'b0;
    endtask

    function automatic void smooth_average(logic [10:0] q, logic [9:0] idle);
        logic [63:0] keep, one, base, r;
        logic [9:0]  m;
        if (q > 0) begin
            keep = (64'd1 << wshift) - 64'd1;
            avg_q = (avg_q * keep + (64'(q) << 16)) >> wshift;
        end else begin
            one = 64'd1 << 24;
            base = one - (64'd1 << (24 - wshift));
            r = one;
            m = idle;
            while (m != 0) begin
                if (m[0]) r = (r * base) >> 24;
                base = (base * base) >> 24;
                m = m >> 1;
            end
            avg_q = (avg_q * r) >> 24;
        end
    endfunction

    function automatic int red_action(logic [10:0] q, logic [10:0] lim, logic [15:0] rnd);
        logic [63:0] minf, maxf, pb, cpb, pa;
        minf = 64'(min_th) << 16;
        maxf = 64'(max_th) << 16;
        if (q >= lim) begin
            since_mark = 0;
            return 2;
        end
        if (minf <= avg_q && avg_q < maxf) begin
            if (since_mark < 65535) since_mark++;
            pb = (64'(max_p) * (avg_q - minf)) / (maxf - minf);
            cpb = 64'(since_mark) * pb;
            if (cpb >= 65536) pa = 64'd65536;
            else begin
                pa = (pb << 16) / (64'd65536 - cpb);
                if (pa > 65536) pa = 64'd65536;
            end
            if (64'(rnd) < pa) begin
                since_mark = 0;
                return 1;
            end
            return 0;
        end
        if (avg_q >= maxf) begin
            since_mark = 0;
            return 1;
        end
        since_mark = -1;
        return 0;
    endfunction

    function automatic verdict_t predict_verdict(packet_t p);
        logic [10:0] q, lim;
        int act;
        q = (p.qlen > 1024) ? 11'd1024 : p.qlen;
        lim = (cap > max_th) ? cap : max_th;
        if (p.ecn != ECN_NOT_ECT) begin
            if (pending && p.ecn != ECN_CE) begin
                pending = 1'b0;
                return VERDICT_MARK;
            end
            smooth_average(q, p.idle);
            act = red_action(q, lim, p.rnd);
            if (act == 2) return VERDICT_DROP;
            if (act == 1) begin
                if (p.ecn == ECN_CE) begin
                    pending = 1'b1;
                    return VERDICT_FORWARD;
                end
                return VERDICT_MARK;
            end
            return VERDICT_FORWARD;
        end
        smooth_average(q, p.idle);
        if (q >= lim) begin
            since_mark = 0;
            return VERDICT_DROP;
        end
        since_mark = -1;
        return VERDICT_FORWARD;
    endfunction

    task automatic write_reg(cfg_index_t idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_MIN_THRESHOLD:   min_th = val[10:0];
            CFG_MAX_THRESHOLD:   max_th = val[10:0];
            CFG_MAX_PROBABILITY: max_p = val;
            CFG_WEIGHT_SHIFT:    wshift = val[3:0];
            CFG_CAPACITY:        cap = val[10:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (verdict_queue.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic set_all(int mn, int mx, int mp, int ws, int cp);
        drain();
        write_reg(CFG_MIN_THRESHOLD, 16'(mn));
        write_reg(CFG_MAX_THRESHOLD, 16'(mx));
        write_reg(CFG_MAX_PROBABILITY, 16'(mp));
        write_reg(CFG_WEIGHT_SHIFT, 16'(ws));
        write_reg(CFG_CAPACITY, 16'(cp));
        cfg_we <= 1'b0;
    endtask

    // Sends one packet; when the expectation is known it is also checked here.
    task automatic send_packet(packet_t p, logic known, verdict_t want, int gap);
        verdict_t v;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        {s_ecn_bits, s_queue_length, s_idle_slots, s_random_value} <= p;
        do @(posedge aclk); while (!s_ready);
        v = predict_verdict(p);
        if (known && v != want) begin
            errors++;
            $display("directed row disagrees: expected %0d predicted %0d", want, v);
        end
        verdict_queue.push_back(v);
    endtask

    function automatic packet_t rand_packet(int qmax);
        packet_t p;
        p.ecn = 2'($urandom_range(0, 3));
        p.qlen = ($urandom_range(0, 9) == 0) ? 11'd0 : 11'($urandom_range(1, qmax));
        if ($urandom_range(0, 30) == 0) p.qlen = 11'($urandom_range(1024, 2047));
        p.idle = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 20));
        p.rnd = 16'($urandom);
        return p;
    endfunction

    // Result side: a drawn wait before each transfer and one long hold-off.
    always @(posedge aclk) begin
        int w;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else if (stall_long > 0) begin
            m_ready <= 1'b0;
            stall_long <= stall_long - 1;
        end else if (m_valid && m_ready) begin
            w = done ? 0 : $urandom_range(0, 19);
            m_ready <= (w == 0);
            rx_wait <= w;
        end else if (rx_wait > 0) begin
            m_ready <= 1'b0;
            rx_wait <= rx_wait - 1;
        end else m_ready <= 1'b1;
    end

    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_queue.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("unexpected transfer: verdict %0d", m_verdict);
            end else begin
                want = verdict_queue.pop_front();
                if (m_verdict !== want) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("verdict mismatch: expected %0d actual %0d", want, m_verdict);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 5000) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    row_t rows[$];

    initial begin
        row_t r;
        packet_t p;
        int qmax;
        apply_reset_model();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        rows.push_back('{'{2'd0, 11'd0, 10'd0, 16'd0}, 1'b1, VERDICT_FORWARD});
        rows.push_back('{'{2'd1, 11'd0, 10'd1023, 16'hFFFF}, 1'b1, VERDICT_FORWARD});
        rows.push_back('{'{2'd0, 11'd100, 10'd0, 16'd0}, 1'b1, VERDICT_DROP});
        rows.push_back('{'{2'd2, 11'd2047, 10'd0, 16'd0}, 1'b1, VERDICT_DROP});
        rows.push_back('{'{2'd3, 11'd1024, 10'd1023, 16'd0}, 1'b1, VERDICT_DROP});
        rows.push_back('{'{2'd0, 11'd99, 10'd0, 16'd0}, 1'b0, VERDICT_FORWARD});
        for (int i = 0; i < 6; i++)
            rows.push_back('{'{2'd3, 11'd90, 10'd0, 16'd0}, 1'b0, VERDICT_FORWARD});
        rows.push_back('{'{2'd1, 11'd90, 10'd0, 16'hFFFF}, 1'b0, VERDICT_FORWARD});
        rows.push_back('{'{2'd2, 11'd90, 10'd0, 16'd0}, 1'b0, VERDICT_FORWARD});
        rows.push_back('{'{2'd0, 11'd0, 10'd5, 16'd0}, 1'b0, VERDICT_FORWARD});
        rows.push_back('{'{2'd3, 11'd0, 10'd512, 16'd0}, 1'b0, VERDICT_FORWARD});
        rows.push_back('{'{2'd1, 11'd0, 10'd0, 16'd1}, 1'b0, VERDICT_FORWARD});
        foreach (rows[i]) send_packet(rows[i].pkt, rows[i].known, rows[i].want, 0);

        set_all(0, 0, 0, 0, 0);
        r = '{'{2'd1, 11'd0, 10'd0, 16'd0}, 1'b1, VERDICT_DROP};
        send_packet(r.pkt, r.known, r.want, 0);
        r = '{'{2'd0, 11'd0, 10'd3, 16'd0}, 1'b1, VERDICT_DROP};
        send_packet(r.pkt, r.known, r.want, 0);

        // Long receiver hold-off while packets keep coming.
        set_all(3, 10, 40000, 2, 1024);
        stall_long <= 300;
        for (int i = 0; i < 20; i++) send_packet(rand_packet(12), 1'b0, VERDICT_FORWARD, 0);

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: set_all(5, 15, 6554, 9, 100);
                1: set_all(1024, 1024, 65535, 15, 1024);
                2: set_all(20, 10, 30000, 1, 30);
                3: set_all(2, 40, 65535, 3, 1);
                4: set_all(0, 1, 1, 4, 60);
                5: set_all(100, 300, 20000, 6, 500);
                default: set_all(8, 30, 12000, 5, 64);
            endcase
            qmax = (ph == 1 || ph == 5) ? 1024 : (max_th > cap ? max_th : cap) + 8;
            for (int i = 0; i < 150; i++) begin
                p = rand_packet(qmax);
                send_packet(p, 1'b0, VERDICT_FORWARD,
                            (i % 50 < 15) ? 0 : $urandom_range(0, 19));
            end
            s_valid <= 1'b0;
            while (verdict_queue.size() != 0) @(posedge aclk);
        end

        done = 1'b1;
        drain();
        if (errors == 0 && mismatches == 0) $display("tb OK");
        else $display("tb NOT OK");
        $finish;
    end
endmodule

// ===== red_ecn_marker_unit.f =====
hdl/rem_pkg.sv
hdl/rem_ctrl.sv
hdl/rem_dpath.sv
hdl/red_ecn_marker_unit.sv
bench/tb.sv
